// ----- rtl/utf8_lenient_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// UTF-8 lenient decoder assertion macros
// Shared assertion forms for the decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_LENIENT_DECODER_CORE_DEFINES_SVH
`define UTF8_LENIENT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ULC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ULC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ulc_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 lenient decoder package
// Types, constants and byte classification shared by the decoder modules.
// ----------------------------------------------------------------------------
package ulc_pkg;

    localparam int unsigned CP_W       = 21;
    localparam int unsigned RUN_BYTES  = 4;
    localparam int unsigned HOLD_BYTES = 3;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] CODE_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] CODE_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] CODE_LEAD4  = 8'hF0;

    localparam logic [2:0] LEN_BAD   = 3'd0;
    localparam logic [2:0] LEN_ASCII = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // A closed group of bytes that the back end decodes with its end known.
    typedef struct packed {
        logic [RUN_BYTES-1:0][7:0] bytes;
        logic [2:0]                len;
    } run_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        priority if (b < ASCII_LIMIT)
        begin
            len = LEN_ASCII;
        end
        else if ((b & MASK_LEAD2) == CODE_LEAD2)
        begin
            len = LEN_TWO;
        end
        else if ((b & MASK_LEAD3) == CODE_LEAD3)
        begin
            len = LEN_THREE;
        end
        else if ((b & MASK_LEAD4) == CODE_LEAD4)
        begin
            len = LEN_FOUR;
        end
        else
        begin
            len = LEN_BAD;
        end
        return len;
    endfunction

endpackage

// ----- rtl/utf8_lenient_decoder_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 lenient decoder core
// Streaming byte to code point decoder with a queue interface on both sides.
// ----------------------------------------------------------------------------
// Input: a byte_value word with final_byte is taken on a clock edge where push
// is high and full is low. Output: while empty is low, the oldest code_point
// and its run_last flag are on the ports; pop high on a clock edge takes it.
// run_last is set on the last code point that one input byte produced.
// Lead bytes of an open sequence give nothing until the sequence closes.
// The word that closes a group passes through the run queue, then the result
// queue. One byte per cycle is sustained for ordinary text. A stream
// ending inside a sequence produces up to three code points, one per cycle
// from the back-end decode unit, while the front keeps taking bytes until
// the two-entry run queue fills. When pop stays low, the two-word result
// queue fills, the back end waits, and full rises once the run queue is full;
// nothing is dropped. Reset clears the open sequence and both queues.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder_core
    import ulc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      byte_value,
    input  logic            final_byte,
    output logic            empty,
    input  logic            pop,
    output logic [CP_W-1:0] code_point,
    output logic            run_last
);

    logic run_push;
    run_t run_wdata;
    logic run_full;
    logic run_pop;
    run_t run_rdata;
    logic run_empty;

    ulc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_value (byte_value),
        .final_byte (final_byte),
        .run_push   (run_push),
        .run_data   (run_wdata),
        .run_full   (run_full)
    );

    ulc_run_fifo u_run_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (run_push),
        .wdata (run_wdata),
        .full  (run_full),
        .pop   (run_pop),
        .rdata (run_rdata),
        .empty (run_empty)
    );

    ulc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_valid  (!run_empty),
        .run_data   (run_rdata),
        .run_pop    (run_pop),
        .empty      (empty),
        .pop        (pop),
        .code_point (code_point),
        .run_last   (run_last)
    );

endmodule

// ----- rtl/ulc_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 lenient decoder front end
// Accepts bytes, holds an open sequence and closes groups into runs.
// ----------------------------------------------------------------------------
`include "utf8_lenient_decoder_core_defines.svh"

module ulc_front
    import ulc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] byte_value,
    input  logic       final_byte,
    output logic       run_push,
    output run_t       run_data,
    input  logic       run_full
);

    logic [HOLD_BYTES-1:0][7:0] pend_reg;
    logic [1:0]                 count_reg;
    logic [1:0]                 count_next;
    logic [2:0]                 seq_reg;
    logic [2:0]                 seq_next;

    logic       accept;
    logic [2:0] byte_len;
    logic [2:0] run_len;
    logic       hold;

    assign full     = run_full;
    assign accept   = push && !run_full;
    assign byte_len = lead_len(byte_value);
    assign run_len  = {1'b0, count_reg} + 3'd1;

    always_comb
    begin
        hold = 1'b0;
        if (!final_byte)
        begin
            if (seq_reg == LEN_BAD)
            begin
                hold = (byte_len >= LEN_TWO);
            end
            else
            begin
                hold = (run_len < seq_reg) && (count_reg < 2'd3);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < HOLD_BYTES; j++)
        begin
            if (j < int'(count_reg))
            begin
                run_data.bytes[j] = pend_reg[j];
            end
            else
            begin
                run_data.bytes[j] = byte_value;
            end
        end
        run_data.bytes[RUN_BYTES-1] = byte_value;
        run_data.len = run_len;
    end

    assign run_push = accept && !hold;

    always_comb
    begin
        count_next = count_reg;
        seq_next   = seq_reg;
        if (accept)
        begin
            if (!hold)
            begin
                count_next = 2'd0;
                seq_next   = LEN_BAD;
            end
            else if (seq_reg == LEN_BAD)
            begin
                count_next = 2'd1;
                seq_next   = byte_len;
            end
            else
            begin
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            seq_reg   <= LEN_BAD;
        end
        else
        begin
            count_reg <= count_next;
            seq_reg   <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold)
        begin
            if (seq_reg == LEN_BAD)
            begin
                pend_reg[0] <= byte_value;
            end
            else
            begin
                pend_reg[count_reg] <= byte_value;
            end
        end
    end

    `ULC_ASSERT_NOW(a_idle_empty, seq_reg == LEN_BAD, count_reg == 2'd0,
        "Bytes held with no open sequence.")
    `ULC_ASSERT_NOW(a_open_partial, seq_reg != LEN_BAD,
        (count_reg != 2'd0) && ({1'b0, count_reg} < seq_reg),
        "Open sequence holds an impossible byte count.")
    `ULC_ASSERT_NEXT(a_final_clears, accept && final_byte, seq_reg == LEN_BAD,
        "Sequence still open after the final byte.")

endmodule

// ----- rtl/ulc_run_fifo.sv -----
// ----------------------------------------------------------------------------
// UTF-8 lenient decoder run queue
// Two-entry queue of closed runs between the front and back ends.
// ----------------------------------------------------------------------------
module ulc_run_fifo
    import ulc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t wdata,
    output logic full,
    input  logic pop,
    output run_t rdata,
    output logic empty
);

    run_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/ulc_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 lenient decoder back end
// Walks a run into a two-word result queue, one code point per non-full cycle.
// ----------------------------------------------------------------------------
`include "utf8_lenient_decoder_core_defines.svh"

module ulc_back
    import ulc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            run_valid,
    input  run_t            run_data,
    output logic            run_pop,
    output logic            empty,
    input  logic            pop,
    output logic [CP_W-1:0] code_point,
    output logic            run_last
);

    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic [CP_W-1:0] res_cp_reg [2];
    logic            res_last_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      res_count_reg;

    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [7:0]      b3;
    logic [2:0]      blen;
    logic [2:0]      avail;
    logic [2:0]      step;
    logic [2:0]      new_pos;
    logic [CP_W-1:0] cp;
    logic            last;
    logic            emit;
    logic            do_pop;

    assign b0    = run_data.bytes[pos_reg];
    assign b1    = run_data.bytes[pos_reg + 2'd1];
    assign b2    = run_data.bytes[pos_reg + 2'd2];
    assign b3    = run_data.bytes[pos_reg + 2'd3];
    assign blen  = lead_len(b0);
    assign avail = run_data.len - {1'b0, pos_reg};

    always_comb
    begin
        cp   = CP_REPLACEMENT;
        step = 3'd1;
        if (blen == LEN_ASCII)
        begin
            cp = {13'd0, b0};
        end
        else if ((blen == LEN_TWO) && (avail >= 3'd2))
        begin
            cp   = {10'd0, b0[4:0], b1[5:0]};
            step = 3'd2;
        end
        else if ((blen == LEN_THREE) && (avail >= 3'd3))
        begin
            cp   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            step = 3'd3;
        end
        else if ((blen == LEN_FOUR) && (avail >= 3'd4))
        begin
            cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            step = 3'd4;
        end
    end

    assign new_pos = {1'b0, pos_reg} + step;
    assign last    = (new_pos >= run_data.len);
    assign emit    = run_valid && (res_count_reg != 2'd2);
    assign run_pop = emit && last;
    assign pos_next = run_pop ? 2'd0 : new_pos[1:0];

    assign empty      = (res_count_reg == 2'd0);
    assign do_pop     = pop && !empty;
    assign code_point = res_cp_reg[rd_ptr_reg];
    assign run_last   = res_last_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            if (emit)
            begin
                pos_reg    <= pos_next;
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (emit && !do_pop)
            begin
                res_count_reg <= res_count_reg + 2'd1;
            end
            else if (do_pop && !emit)
            begin
                res_count_reg <= res_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_cp_reg[wr_ptr_reg]   <= cp;
            res_last_reg[wr_ptr_reg] <= last;
        end
    end

    `ULC_ASSERT_NOW(a_res_bound, 1'b1, res_count_reg != 2'd3,
        "Result queue count out of range.")
    `ULC_ASSERT_NOW(a_pos_inside, run_valid && (pos_reg != 2'd0),
        {1'b0, pos_reg} < run_data.len,
        "Decode position past the end of the run.")
    `ULC_ASSERT_NEXT(a_pos_rewind, run_pop, pos_reg == 2'd0,
        "Decode position not rewound after a run completed.")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 lenient decoder core testbench
// Feeds byte streams through the decoder and compares every code point and
// run_last flag against a cycle-free decode of the same bytes. Covers ASCII,
// invalid leads, complete and truncated sequences, and random text with
// random stalls on both the byte and the code point side.
// ----------------------------------------------------------------------------
module testbench;
    import ulc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
    } decoded_t;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            push       = 1'b0;
    logic            full;
    logic [7:0]      byte_value = 8'h00;
    logic            final_byte = 1'b0;
    logic            empty;
    logic            pop        = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            run_last;

    decoded_t   expected_points[$];
    logic [7:0] held_bytes[3];
    int         held_count  = 0;
    logic [2:0] open_length = LEN_BAD;

    int errors        = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int send_gap_pct  = 0;
    int pop_stall_pct = 0;
    int pop_hold      = 0;

    utf8_lenient_decoder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_value (byte_value),
        .final_byte (final_byte),
        .empty      (empty),
        .pop        (pop),
        .code_point (code_point),
        .run_last   (run_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [2:0] byte_class(input logic [7:0] b);
        if (b < ASCII_LIMIT)
        begin
            return LEN_ASCII;
        end
        if ((b & MASK_LEAD2) == CODE_LEAD2)
        begin
            return LEN_TWO;
        end
        if ((b & MASK_LEAD3) == CODE_LEAD3)
        begin
            return LEN_THREE;
        end
        if ((b & MASK_LEAD4) == CODE_LEAD4)
        begin
            return LEN_FOUR;
        end
        return LEN_BAD;
    endfunction

    // Updates the open sequence and queues the code points this byte releases.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]      run[4];
        logic [CP_W-1:0] cps[3];
        logic [2:0]      len;
        decoded_t        item;
        int              n;
        int              i;
        int              k;
        for (i = 0; i < held_count; i++)
        begin
            run[i] = held_bytes[i];
        end
        run[held_count] = b;
        n = held_count + 1;
        if (!fin)
        begin
            if (open_length == LEN_BAD)
            begin
                len = byte_class(b);
                if (len >= LEN_TWO)
                begin
                    held_bytes[0] = b;
                    held_count = 1;
                    open_length = len;
                    return;
                end
            end
            else if (n < open_length && held_count < 3)
            begin
                held_bytes[held_count] = b;
                held_count++;
                return;
            end
        end
        i = 0;
        k = 0;
        while (i < n && k < 3)
        begin
            len = byte_class(run[i]);
            if (len == LEN_ASCII)
            begin
                cps[k] = {13'b0, run[i]};
                i += 1;
            end
            else if (len == LEN_TWO && i + 1 < n)
            begin
                cps[k] = {10'b0, run[i][4:0], run[i+1][5:0]};
                i += 2;
            end
            else if (len == LEN_THREE && i + 2 < n)
            begin
                cps[k] = {5'b0, run[i][3:0], run[i+1][5:0], run[i+2][5:0]};
                i += 3;
            end
            else if (len == LEN_FOUR && i + 3 < n)
            begin
                cps[k] = {run[i][2:0], run[i+1][5:0], run[i+2][5:0], run[i+3][5:0]};
                i += 4;
            end
            else
            begin
                cps[k] = CP_REPLACEMENT;
                i += 1;
            end
            k++;
        end
        for (i = 0; i < k; i++)
        begin
            item.cp = cps[i];
            item.last = (i == k - 1);
            expected_points.insert(expected_points.size(), item);
        end
        held_count = 0;
        open_length = LEN_BAD;
    endfunction

    function automatic int stall_length();
        if ($urandom_range(7) == 0)
        begin
            return $urandom_range(30, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if ($urandom_range(99) < send_gap_pct)
        begin
            gap = stall_length();
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        byte_value <= b;
        final_byte <= fin;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        decode_byte(b, fin);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        @(negedge clk);
        while (expected_points.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else if ($urandom_range(99) < pop_stall_pct)
        begin
            pop <= 1'b0;
            pop_hold = stall_length() - 1;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_word
        decoded_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_points.size() == 0)
            begin
                $error("Unexpected word: code_point %h run_last %b", code_point, run_last);
                errors++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (code_point !== want.cp)
                begin
                    $error("code_point mismatch: expected %h, actual %h", want.cp, code_point);
                    errors++;
                end
                if (run_last !== want.last)
                begin
                    $error("run_last mismatch: expected %b, actual %b", want.last, run_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("Timeout with %0d words still expected", expected_points.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_single_bytes();
        send_gap_pct = 10;
        pop_stall_pct = 10;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_for_results();
    endtask

    task automatic test_complete_sequences();
        send_gap_pct = 0;
        pop_stall_pct = 0;
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        wait_for_results();
    endtask

    task automatic test_truncated_streams();
        send_gap_pct = 10;
        pop_stall_pct = 30;
        send_byte(8'hC3, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        wait_for_results();
    endtask

    // Mostly well-formed characters with random payload bits, some noise,
    // some broken continuation bytes, and streams that end at random points.
    task automatic test_random_text(input int count, input int gap_pct, input int stall_pct);
        logic [7:0] seq[4];
        int         seq_len;
        int         kind;
        int         j;
        int         start;
        logic       fin;
        send_gap_pct = gap_pct;
        pop_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < count)
        begin
            kind = $urandom_range(9);
            seq[0] = 8'($urandom);
            if (kind <= 3)
            begin
                seq_len = 1;
                seq[0][7] = 1'b0;
            end
            else if (kind <= 5)
            begin
                seq_len = 2;
                seq[0][7:5] = 3'b110;
            end
            else if (kind <= 7)
            begin
                seq_len = 3;
                seq[0][7:4] = 4'b1110;
            end
            else if (kind == 8)
            begin
                seq_len = 4;
                seq[0][7:3] = 5'b11110;
            end
            else
            begin
                seq_len = 1;
            end
            for (j = 1; j < seq_len; j++)
            begin
                seq[j] = 8'($urandom);
                if ($urandom_range(9) != 0)
                begin
                    seq[j][7:6] = 2'b10;
                end
            end
            for (j = 0; j < seq_len; j++)
            begin
                fin = ($urandom_range(15) == 0);
                send_byte(seq[j], fin);
                if (fin)
                begin
                    break;
                end
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_single_bytes();
        test_complete_sequences();
        test_truncated_streams();
        test_random_text(80, 0, 0);
        test_random_text(80, 25, 20);
        test_random_text(80, 5, 60);
        test_random_text(80, 40, 5);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
